// File: hdl/ifs_pkg.sv
// types, constants and codes for the indexed fifo with search
// used by every module of the block; depends on nothing
`default_nettype none
package ifs_pkg;

   localparam int DEPTH  = 64;
   localparam int WORD_W = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_READ   = 3'd3,
      OP_WRITE  = 3'd4,
      OP_FIND   = 3'd5,
      OP_DELETE = 3'd6,
      OP_SWAP   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT,
      CELL_SWAP
   } cell_cmd_type;

   typedef struct packed {
      op_type              operation;
      logic [5:0]          position;
      logic [5:0]          other_position;
      logic [WORD_W-1:0]   data_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_word;
      logic [5:0]          found_index;
      status_type          status;
      logic [6:0]          entry_count;
   } rsp_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [IDX_W-1:0]    pos;
      logic [IDX_W-1:0]    oth;
      logic [WORD_W-1:0]   key;
      logic [WORD_W-1:0]   word_pos;
      logic [WORD_W-1:0]   word_oth;
      logic [CNT_W-1:0]    count;
      logic                scan_key;
   } cell_ctl_type;

   typedef struct packed {
      logic                hit_a;
      logic [WORD_W-1:0]   word_a;
      logic [IDX_W-1:0]    idx_a;
      logic [WORD_W-1:0]   word_b;
   } scan_type;

endpackage
`default_nettype wire

// File: hdl/ifs_cell.sv
// one storage cell of the queue: a word plus a scan carry passed toward the head
// depends on ifs_pkg
`default_nettype none
module ifs_cell (
   input  wire logic                        clock,
   input  wire logic [ifs_pkg::IDX_W-1:0]   cell_index,
   input  wire ifs_pkg::cell_ctl_type       ctl,
   input  wire logic [ifs_pkg::WORD_W-1:0]  next_word,
   input  wire ifs_pkg::scan_type           carry_in,
   output      logic [ifs_pkg::WORD_W-1:0]  word,
   output      ifs_pkg::scan_type           carry_out
);

   logic [ifs_pkg::WORD_W-1:0] word_ff, word_in;
   ifs_pkg::scan_type          carry_ff, carry_in_next;
   logic                       hit_a, hit_b, at_pos, at_oth, live;

   assign at_pos = (cell_index == ctl.pos);
   assign at_oth = (cell_index == ctl.oth);
   assign live   = (ifs_pkg::CNT_W'(cell_index) < ctl.count);
   assign hit_a  = ctl.scan_key ? ((word_ff == ctl.key) && live) : at_pos;
   assign hit_b  = at_oth;

   always_comb begin
      word_in = word_ff;
      case (ctl.cmd)
         ifs_pkg::CELL_HOLD: begin
            word_in = word_ff;
         end
         ifs_pkg::CELL_WRITE: begin
            if (at_pos) word_in = ctl.word_pos;
         end
         ifs_pkg::CELL_SHIFT: begin
            if (cell_index >= ctl.pos) word_in = next_word;
         end
         ifs_pkg::CELL_SWAP: begin
            if (at_pos) word_in = ctl.word_pos;
            else if (at_oth) word_in = ctl.word_oth;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // lower cells override, so the head ends with the first hit
   always_comb begin
      carry_in_next.hit_a  = hit_a | carry_in.hit_a;
      carry_in_next.word_a = hit_a ? word_ff : carry_in.word_a;
      carry_in_next.idx_a  = hit_a ? cell_index : carry_in.idx_a;
      carry_in_next.word_b = hit_b ? word_ff : carry_in.word_b;
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      carry_ff <= carry_in_next;
   end

   assign word      = word_ff;
   assign carry_out = carry_ff;

endmodule
`default_nettype wire

// File: hdl/ifs_ctrl.sv
// request decode, entry count, scan sequencer and result register
// depends on ifs_pkg
`default_nettype none
module ifs_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire ifs_pkg::req_type            req_item,
   output      logic                        busy,
   output      logic                        rsp_strobe,
   output      ifs_pkg::rsp_type            rsp_item,
   output      ifs_pkg::cell_ctl_type       cell_ctl,
   input  wire logic [ifs_pkg::WORD_W-1:0]  head_word,
   input  wire ifs_pkg::scan_type           scan_result
);

   ifs_pkg::state_type          state_ff, state_in;
   logic [ifs_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   logic [ifs_pkg::CNT_W-1:0]   count_ff, count_in;
   ifs_pkg::req_type            req_ff, req_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ifs_pkg::rsp_type            rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic pos_ok;
      logic oth_ok;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.read_word   = '0;
      rsp_in.found_index = '0;
      rsp_in.status      = ifs_pkg::STAT_OK;
      pos_ok = (ifs_pkg::CNT_W'(req_item.position) < count_ff);
      oth_ok = (ifs_pkg::CNT_W'(req_item.other_position) < count_ff);

      cell_ctl.cmd      = ifs_pkg::CELL_HOLD;
      cell_ctl.pos      = ifs_pkg::IDX_W'(req_ff.position);
      cell_ctl.oth      = ifs_pkg::IDX_W'(req_ff.other_position);
      cell_ctl.key      = req_ff.data_word;
      cell_ctl.word_pos = req_ff.data_word;
      cell_ctl.word_oth = '0;
      cell_ctl.count    = count_ff;
      cell_ctl.scan_key = (req_ff.operation == ifs_pkg::OP_FIND);

      case (state_ff)
         ifs_pkg::ST_IDLE: begin
            if (start) begin
               req_in            = req_item;
               rsp_valid_in      = 1'b1;
               cell_ctl.pos      = ifs_pkg::IDX_W'(req_item.position);
               cell_ctl.word_pos = req_item.data_word;
               case (req_item.operation)
                  ifs_pkg::OP_PUSH: begin
                     if (count_ff == ifs_pkg::CNT_W'(ifs_pkg::DEPTH)) begin
                        rsp_in.status = ifs_pkg::STAT_FULL;
                     end else begin
                        cell_ctl.cmd = ifs_pkg::CELL_WRITE;
                        cell_ctl.pos = ifs_pkg::IDX_W'(count_ff);
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  ifs_pkg::OP_POP, ifs_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ifs_pkg::STAT_EMPTY;
                     end else begin
                        rsp_in.read_word = head_word;
                        if (req_item.operation == ifs_pkg::OP_POP) begin
                           cell_ctl.cmd = ifs_pkg::CELL_SHIFT;
                           cell_ctl.pos = '0;
                           count_in     = count_ff - 1'b1;
                        end
                     end
                  end
                  ifs_pkg::OP_READ: begin
                     if (!pos_ok) begin
                        rsp_in.status = ifs_pkg::STAT_BADPOS;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ifs_pkg::ST_SCAN;
                        cnt_in       = '0;
                     end
                  end
                  ifs_pkg::OP_WRITE: begin
                     if (!pos_ok) rsp_in.status = ifs_pkg::STAT_BADPOS;
                     else cell_ctl.cmd = ifs_pkg::CELL_WRITE;
                  end
                  ifs_pkg::OP_FIND: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ifs_pkg::ST_SCAN;
                     cnt_in       = '0;
                  end
                  ifs_pkg::OP_DELETE: begin
                     if (!pos_ok) begin
                        rsp_in.status = ifs_pkg::STAT_BADPOS;
                     end else begin
                        cell_ctl.cmd = ifs_pkg::CELL_SHIFT;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  ifs_pkg::OP_SWAP: begin
                     if (!pos_ok || !oth_ok) begin
                        rsp_in.status = ifs_pkg::STAT_BADPOS;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ifs_pkg::ST_SCAN;
                        cnt_in       = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ifs_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ifs_pkg::IDX_W'(ifs_pkg::DEPTH - 1)) state_in = ifs_pkg::ST_FINISH;
         end
         ifs_pkg::ST_FINISH: begin
            state_in     = ifs_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            case (req_ff.operation)
               ifs_pkg::OP_READ: begin
                  rsp_in.read_word = scan_result.word_a;
               end
               ifs_pkg::OP_FIND: begin
                  if (scan_result.hit_a) rsp_in.found_index = 6'(scan_result.idx_a);
                  else rsp_in.status = ifs_pkg::STAT_NOTFOUND;
               end
               ifs_pkg::OP_SWAP: begin
                  cell_ctl.cmd      = ifs_pkg::CELL_SWAP;
                  cell_ctl.word_pos = scan_result.word_b;
                  cell_ctl.word_oth = scan_result.word_a;
               end
               default: begin
                  rsp_in.status = ifs_pkg::STAT_OK;
               end
            endcase
         end
         default: begin
            state_in = ifs_pkg::ST_IDLE;
         end
      endcase
      rsp_in.entry_count = 7'(count_in);
   end

   assign busy       = (state_ff != ifs_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

// File: hdl/indexed_fifo_with_search.sv
// top level of the indexed fifo with search: controller and row of cells
// depends on ifs_pkg, ifs_ctrl, ifs_cell
//
// An ordered queue of 64 words of 64 bits, head at position 0. A request is
// transferred on the rising edge where start is high and busy is low; req_item
// carries the operation, one or two positions and a data word. Each request
// gives exactly one result: rsp_strobe is high for one cycle while rsp_item
// holds the word, found index, status and entry count after the operation.
// The receiver cannot stall, so the result must be taken in that cycle.
// Push, pop, peek, write and delete (and any request that fails its checks)
// finish without a scan: the result shows the cycle after the transfer, and busy
// stays low so a new request may follow at once. Read, find and swap walk a
// carry down the row of cells toward the head, one cell a cycle; they hold
// busy high through the ST_SCAN and ST_FINISH states and give their result
// after ST_FINISH. Reset empties the queue and returns to idle; the stored
// words are not cleared.
`default_nettype none
module indexed_fifo_with_search (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ifs_pkg::req_type  req_item,
   output      logic              busy,
   output      logic              rsp_strobe,
   output      ifs_pkg::rsp_type  rsp_item
);

   ifs_pkg::cell_ctl_type       cell_ctl;
   logic [ifs_pkg::WORD_W-1:0]  words [ifs_pkg::DEPTH];
   ifs_pkg::scan_type           carries [ifs_pkg::DEPTH + 1];

   assign carries[ifs_pkg::DEPTH] = '0;

   ifs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_item    (req_item),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .cell_ctl    (cell_ctl),
      .head_word   (words[0]),
      .scan_result (carries[0])
   );

   for (genvar g = 0; g < ifs_pkg::DEPTH; g++) begin : g_cell
      logic [ifs_pkg::WORD_W-1:0] next_word;
      if (g == ifs_pkg::DEPTH - 1) begin : g_last
         assign next_word = '0;
      end else begin : g_mid
         assign next_word = words[g + 1];
      end
      ifs_cell u_cell (
         .clock      (clock),
         .cell_index (ifs_pkg::IDX_W'(g)),
         .ctl        (cell_ctl),
         .next_word  (next_word),
         .carry_in   (carries[g + 1]),
         .word       (words[g]),
         .carry_out  (carries[g])
      );
   end

endmodule
`default_nettype wire
